[rtl/swik_pkg.sv]
// Shared constants, register codes and arithmetic helpers of the swerve kinematics unit.
package swik_pkg;

    localparam int SPEED_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int CORDIC_N = 30;
    localparam int CW       = 33;
    localparam int ABW      = 30;
    localparam int SQW      = 60;
    localparam int MW       = 30;
    localparam int ABCD_MAX = 536870911;

    localparam logic signed [CW-1:0] CORDIC_K = 33'sd652032874;

    localparam logic [1:0] REG_HALF_LENGTH = 2'd0;
    localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;
    localparam logic [1:0] REG_ROT_SCALE   = 2'd2;

    localparam logic [15:0] HALF_LENGTH_RST = 16'd2816;
    localparam logic [15:0] HALF_WIDTH_RST  = 16'd2816;
    localparam logic [15:0] ROT_SCALE_RST   = 16'd3277;

    // atan(2^-i) on a 32-bit turn
    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // round half away from zero, then drop s fraction bits
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v, input int s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

[rtl/swik_rot_cell.sv]
// One CORDIC rotation step of the heading sine/cosine chain.
module swik_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                               clk,
    input  logic                               adv,
    input  logic signed [swik_pkg::CW-1:0]     x_in,
    input  logic signed [swik_pkg::CW-1:0]     y_in,
    input  logic signed [swik_pkg::CW-1:0]     z_in,
    output logic signed [swik_pkg::CW-1:0]     x_out,
    output logic signed [swik_pkg::CW-1:0]     y_out,
    output logic signed [swik_pkg::CW-1:0]     z_out
);
    localparam int CW = swik_pkg::CW;
    localparam logic signed [CW-1:0] ATAN = $signed({1'b0, swik_pkg::atan_step(STEP)});

    logic signed [CW-1:0] dx, dy, x_next, y_next, z_next;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!z_in[CW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

[rtl/swik_vec_cell.sv]
// One CORDIC vectoring step of a wheel angle chain.
module swik_vec_cell #(
    parameter int STEP = 0
) (
    input  logic                               clk,
    input  logic                               adv,
    input  logic signed [swik_pkg::CW-1:0]     x_in,
    input  logic signed [swik_pkg::CW-1:0]     y_in,
    input  logic [31:0]                        z_in,
    output logic signed [swik_pkg::CW-1:0]     x_out,
    output logic signed [swik_pkg::CW-1:0]     y_out,
    output logic [31:0]                        z_out
);
    localparam int CW = swik_pkg::CW;
    localparam logic [31:0] ATAN = swik_pkg::atan_step(STEP);

    logic signed [CW-1:0] dx, dy, x_next, y_next;
    logic signed [CW-1:0] x_reg, y_reg;
    logic [31:0] z_next, z_reg;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[CW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

[rtl/swik_sqrt_cell.sv]
// One digit step of the integer square root that forms a wheel speed.
module swik_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [swik_pkg::SQW-1:0]      n_in,
    input  logic [swik_pkg::SQW-1:0]      r_in,
    output logic [swik_pkg::SQW-1:0]      n_out,
    output logic [swik_pkg::SQW-1:0]      r_out
);
    localparam int SQW = swik_pkg::SQW;
    localparam logic [SQW-1:0] BIT =
        SQW'(1) << (2 * (swik_pkg::CORDIC_N - 1) - 2 * STEP);

    logic [SQW-1:0] trial, n_next, r_next, n_reg, r_reg;

    always_comb
    begin
        trial = r_in + BIT;
        if (n_in >= trial)
        begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;
endmodule

[rtl/swik_div_cell.sv]
// One restoring division step of the speed normalization.
module swik_div_cell #(
    parameter int SPEED_BITS = swik_pkg::SPEED_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [swik_pkg::MW-1:0]      rem_in,
    input  logic [SPEED_BITS-1:0]        lo_in,
    input  logic [swik_pkg::MW-1:0]      div_in,
    output logic [swik_pkg::MW-1:0]      rem_out,
    output logic [SPEED_BITS-1:0]        lo_out
);
    localparam int MW = swik_pkg::MW;

    logic [MW:0]           trial;
    logic                  ge;
    logic [MW-1:0]         rem_next, rem_reg;
    logic [SPEED_BITS-1:0] lo_next, lo_reg;

    always_comb
    begin
        trial    = {rem_in, lo_in[SPEED_BITS-1]};
        ge       = trial >= {1'b0, div_in};
        rem_next = ge ? MW'(trial - {1'b0, div_in}) : MW'(trial);
        lo_next  = {lo_in[SPEED_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
        end
    end

    assign rem_out = rem_reg;
    assign lo_out  = lo_reg;
endmodule

[rtl/swerve_inverse_kinematics_unit.sv]
// Swerve drive inverse kinematics: joystick command in, four wheel speeds and angles out.
//
// Input stream s_*: one transaction per joystick command (x, y, rotation, heading).
// Output stream m_*: one transaction per command with four speeds and four angles.
// APB port: half_length at 0x0, half_width at 0x4, rot_scale at 0x8; write only while idle.
//
// The datapath is a row of cells that all advance together: 30 rotation cells for the
// heading sine/cosine, three multiply and round stages, two stages that form the squares,
// four lanes of 30 square-root cells running beside four lanes of 30 vectoring cells,
// one max stage and SPEED_BITS restoring-division cells.
// Throughput: one command per clock while the row is not held. The whole row holds only
// while its last cell carries a result and the output register is full and stalled;
// s_tready drops exactly then. While the last cell is empty the row keeps advancing,
// so bubbles close up behind a waiting result.
// Reset clears the valid bits and the output valid, and restores the three registers.
module swerve_inverse_kinematics_unit #(
    parameter int SPEED_BITS = swik_pkg::SPEED_BITS_DEF,
    parameter int ANGLE_BITS = swik_pkg::ANGLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // x_speed, y_speed, rot_speed, heading
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // speed_fl, fr, bl, br, angle_fl, fr, bl, br
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int N    = swik_pkg::CORDIC_N;
    localparam int CW   = swik_pkg::CW;
    localparam int ABW  = swik_pkg::ABW;
    localparam int SQW  = swik_pkg::SQW;
    localparam int MW   = swik_pkg::MW;
    localparam int NW   = SPEED_BITS + MW;
    localparam int NST  = 2 * N + 7 + SPEED_BITS;

    typedef struct packed {
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] rs;
        logic               flip;
    } rot_pay_t;

    typedef struct packed {
        logic [MW-1:0]      dvs;
        logic               big;
        logic [3:0][15:0]   lowv;
        logic [3:0][15:0]   ang;
    } div_pay_t;

    function automatic logic signed [ABW-1:0] clamp_abcd(input logic signed [33:0] v);
        logic signed [33:0] lim;
        lim = 34'(swik_pkg::ABCD_MAX);
        if (v > lim)
            return ABW'(lim);
        else if (v < -lim)
            return ABW'(-lim);
        return ABW'(v);
    endfunction

    // configuration
    logic [15:0] half_length_reg, half_width_reg, rot_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= swik_pkg::HALF_LENGTH_RST;
            half_width_reg  <= swik_pkg::HALF_WIDTH_RST;
            rot_scale_reg   <= swik_pkg::ROT_SCALE_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                swik_pkg::REG_HALF_LENGTH: half_length_reg <= pwdata[15:0];
                swik_pkg::REG_HALF_WIDTH:  half_width_reg  <= pwdata[15:0];
                swik_pkg::REG_ROT_SCALE:   rot_scale_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            swik_pkg::REG_HALF_LENGTH: prdata = {16'h0, half_length_reg};
            swik_pkg::REG_HALF_WIDTH:  prdata = {16'h0, half_width_reg};
            swik_pkg::REG_ROT_SCALE:   prdata = {16'h0, rot_scale_reg};
            default:                   prdata = 32'h0;
        endcase
    end

    assign pready = 1'b1;

    // flow control
    logic             adv;
    logic [NST-1:0]   vld_reg;
    logic             m_tvalid_reg;
    logic [127:0]     m_tdata_reg;

    assign adv      = !(vld_reg[NST-1] && m_tvalid_reg && !m_tready);
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // input stage: fold heading into the right half-plane
    logic [15:0]          hd, hz;
    logic                 flip;
    logic signed [CW-1:0] z0, z0_reg;
    rot_pay_t             rpay_reg [0:N];

    always_comb
    begin
        hd   = s_tdata[63:48];
        flip = (hd >= 16'h4000) && (hd <= 16'hBFFF);
        hz   = flip ? {~hd[15], hd[14:0]} : hd;
        z0   = CW'($signed({hz, 16'h0}));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z0_reg         <= z0;
            rpay_reg[0].xs <= $signed(s_tdata[15:0]);
            rpay_reg[0].ys <= $signed(s_tdata[31:16]);
            rpay_reg[0].rs <= $signed(s_tdata[47:32]);
            rpay_reg[0].flip <= flip;
        end
    end

    // sine/cosine chain
    logic signed [CW-1:0] rx [0:N];
    logic signed [CW-1:0] ry [0:N];
    logic signed [CW-1:0] rz [0:N];

    assign rx[0] = swik_pkg::CORDIC_K;
    assign ry[0] = '0;
    assign rz[0] = z0_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_rot
        swik_rot_cell #(.STEP(k)) u_cell (
            .clk   (clk),
            .adv   (adv),
            .x_in  (rx[k]),
            .y_in  (ry[k]),
            .z_in  (rz[k]),
            .x_out (rx[k+1]),
            .y_out (ry[k+1]),
            .z_out (rz[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
                rpay_reg[k+1] <= rpay_reg[k];
        end
    end

    // multiply stages
    logic signed [CW-1:0] cs, sn;
    logic signed [48:0]   p_yc_reg, p_xs_reg, p_xc_reg, p_ys_reg;
    logic signed [32:0]   r_reg;
    logic signed [49:0]   sum_x, sum_y;
    logic signed [31:0]   tx_reg, ty_reg;
    logic signed [49:0]   pl_reg, pw_reg;
    logic signed [31:0]   yl, yw;
    logic signed [ABW-1:0] a_reg, b_reg, c_reg, d_reg;

    always_comb
    begin
        cs    = rpay_reg[N].flip ? -rx[N] : rx[N];
        sn    = rpay_reg[N].flip ? -ry[N] : ry[N];
        sum_x = 50'(p_yc_reg) + 50'(p_xs_reg);
        sum_y = 50'(p_xc_reg) - 50'(p_ys_reg);
        yl    = 32'(swik_pkg::round_shift(64'(pl_reg), 19));
        yw    = 32'(swik_pkg::round_shift(64'(pw_reg), 19));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_yc_reg <= rpay_reg[N].ys * cs;
            p_xs_reg <= rpay_reg[N].xs * sn;
            p_xc_reg <= rpay_reg[N].xs * cs;
            p_ys_reg <= rpay_reg[N].ys * sn;
            r_reg    <= rpay_reg[N].rs * $signed({1'b0, rot_scale_reg});

            tx_reg   <= 32'(swik_pkg::round_shift(64'(sum_x), 25));
            ty_reg   <= 32'(swik_pkg::round_shift(64'(sum_y), 25));
            pl_reg   <= r_reg * $signed({1'b0, half_length_reg});
            pw_reg   <= r_reg * $signed({1'b0, half_width_reg});

            a_reg    <= clamp_abcd(34'(tx_reg) - 34'(yl));
            b_reg    <= clamp_abcd(34'(tx_reg) + 34'(yl));
            c_reg    <= clamp_abcd(34'(ty_reg) - 34'(yw));
            d_reg    <= clamp_abcd(34'(ty_reg) + 34'(yw));
        end
    end

    // squares, then sums and vectoring setup
    logic [ABW-1:0]        a_abs, b_abs, c_abs, d_abs;
    logic [SQW-1:0]        sqa_reg, sqb_reg, sqc_reg, sqd_reg;
    logic signed [ABW-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [ABW-1:0] px [0:3];
    logic signed [ABW-1:0] py [0:3];

    always_comb
    begin
        a_abs = a_reg[ABW-1] ? ABW'(-a_reg) : ABW'(a_reg);
        b_abs = b_reg[ABW-1] ? ABW'(-b_reg) : ABW'(b_reg);
        c_abs = c_reg[ABW-1] ? ABW'(-c_reg) : ABW'(c_reg);
        d_abs = d_reg[ABW-1] ? ABW'(-d_reg) : ABW'(d_reg);
        // angle lanes: fl (A,C), fr (B,C), bl (A,D), br (B,D)
        px[0] = a2_reg; py[0] = c2_reg;
        px[1] = b2_reg; py[1] = c2_reg;
        px[2] = a2_reg; py[2] = d2_reg;
        px[3] = b2_reg; py[3] = d2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqa_reg <= a_abs * a_abs;
            sqb_reg <= b_abs * b_abs;
            sqc_reg <= c_abs * c_abs;
            sqd_reg <= d_abs * d_abs;
            a2_reg  <= a_reg;
            b2_reg  <= b_reg;
            c2_reg  <= c_reg;
            d2_reg  <= d_reg;
        end
    end

    logic [SQW-1:0]       sqn [0:N][0:3];
    logic [SQW-1:0]       sqr [0:N][0:3];
    logic signed [CW-1:0] vx  [0:N][0:3];
    logic signed [CW-1:0] vy  [0:N][0:3];
    logic [31:0]          vz  [0:N][0:3];
    logic [SQW-1:0]       n_reg [0:3];
    logic signed [CW-1:0] vx0_reg [0:3];
    logic signed [CW-1:0] vy0_reg [0:3];
    logic [31:0]          vz0_reg [0:3];
    logic [3:0]           zf_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // speed lanes: fl (A,D), fr (B,C), bl (B,D), br (A,C)
            n_reg[0] <= sqa_reg + sqd_reg;
            n_reg[1] <= sqb_reg + sqc_reg;
            n_reg[2] <= sqb_reg + sqd_reg;
            n_reg[3] <= sqa_reg + sqc_reg;
            for (int l = 0; l < 4; l++)
            begin
                zf_reg[0][l] <= (px[l] == '0) && (py[l] == '0);
                vx0_reg[l]   <= px[l][ABW-1] ? -CW'(px[l]) : CW'(px[l]);
                vy0_reg[l]   <= px[l][ABW-1] ? -CW'(py[l]) : CW'(py[l]);
                vz0_reg[l]   <= px[l][ABW-1] ? 32'h8000_0000 : 32'h0;
            end
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_lane0
        assign sqn[0][l] = n_reg[l];
        assign sqr[0][l] = '0;
        assign vx[0][l]  = vx0_reg[l];
        assign vy[0][l]  = vy0_reg[l];
        assign vz[0][l]  = vz0_reg[l];
    end

    // square-root and vectoring rows, side by side
    for (genvar k = 0; k < N; k++)
    begin : g_mid
        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            swik_sqrt_cell #(.STEP(k)) u_sqrt (
                .clk   (clk),
                .adv   (adv),
                .n_in  (sqn[k][l]),
                .r_in  (sqr[k][l]),
                .n_out (sqn[k+1][l]),
                .r_out (sqr[k+1][l])
            );

            swik_vec_cell #(.STEP(k)) u_vec (
                .clk   (clk),
                .adv   (adv),
                .x_in  (vx[k][l]),
                .y_in  (vy[k][l]),
                .z_in  (vz[k][l]),
                .x_out (vx[k+1][l]),
                .y_out (vy[k+1][l]),
                .z_out (vz[k+1][l])
            );
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                zf_reg[k+1] <= zf_reg[k];
        end
    end

    // max, dividend setup and angle rounding
    logic [MW-1:0]  sp [0:3];
    logic [MW-1:0]  m01, m23, mx;
    logic [NW-1:0]  num [0:3];
    logic [NW-1:0]  lows [0:3];
    logic [31:0]    zr [0:3];
    div_pay_t       mx_pay;
    logic [MW-1:0]  drem [0:SPEED_BITS][0:3];
    logic [SPEED_BITS-1:0] dlo [0:SPEED_BITS][0:3];
    logic [MW-1:0]  drem0_reg [0:3];
    logic [SPEED_BITS-1:0] dlo0_reg [0:3];
    div_pay_t       dpay_reg [0:SPEED_BITS];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
            sp[l] = sqr[N][l][MW-1:0];
        m01 = (sp[1] > sp[0]) ? sp[1] : sp[0];
        m23 = (sp[3] > sp[2]) ? sp[3] : sp[2];
        mx  = (m23 > m01) ? m23 : m01;
        mx_pay.dvs = mx;
        mx_pay.big = mx > MW'(32'd1 << 20);
        for (int l = 0; l < 4; l++)
        begin
            num[l]  = (NW'(sp[l]) << (SPEED_BITS - 1)) + NW'(mx >> 1);
            lows[l] = (NW'(sp[l]) << (SPEED_BITS - 1)) + NW'(32'd1 << 19);
            mx_pay.lowv[l] = 16'(lows[l] >> 20);
            zr[l] = vz[N][l] + (32'd1 << (31 - ANGLE_BITS));
            mx_pay.ang[l] = zf_reg[N][l] ? 16'h0 : 16'(zr[l] >> (32 - ANGLE_BITS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dpay_reg[0] <= mx_pay;
            for (int l = 0; l < 4; l++)
            begin
                drem0_reg[l] <= num[l][NW-1:SPEED_BITS];
                dlo0_reg[l]  <= num[l][SPEED_BITS-1:0];
            end
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_div0
        assign drem[0][l] = drem0_reg[l];
        assign dlo[0][l]  = dlo0_reg[l];
    end

    // normalization row
    for (genvar k = 0; k < SPEED_BITS; k++)
    begin : g_div
        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            swik_div_cell #(.SPEED_BITS(SPEED_BITS)) u_div (
                .clk     (clk),
                .adv     (adv),
                .rem_in  (drem[k][l]),
                .lo_in   (dlo[k][l]),
                .div_in  (dpay_reg[k].dvs),
                .rem_out (drem[k+1][l]),
                .lo_out  (dlo[k+1][l])
            );
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dpay_reg[k+1] <= dpay_reg[k];
        end
    end

    // output register
    logic [127:0] res;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            res[16*l +: 16] = dpay_reg[SPEED_BITS].big ? 16'(dlo[SPEED_BITS][l])
                                                       : dpay_reg[SPEED_BITS].lowv[l];
            res[64 + 16*l +: 16] = dpay_reg[SPEED_BITS].ang[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (!m_tvalid_reg || m_tready)
            m_tvalid_reg <= vld_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[NST-1] && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

[rtl/swik_checker.sv]
// Port-level checks of the swerve kinematics unit, bound to the top level.
module swik_checker #(
    parameter int SPEED_BITS = swik_pkg::SPEED_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [3:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata
);
    localparam logic [16:0] SPEED_MAX = 17'(1) << (SPEED_BITS - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transaction changed");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (SPEED_BITS > 16) ||
                     (({1'b0, m_tdata[15:0]} <= SPEED_MAX) &&
                      ({1'b0, m_tdata[31:16]} <= SPEED_MAX) &&
                      ({1'b0, m_tdata[47:32]} <= SPEED_MAX) &&
                      ({1'b0, m_tdata[63:48]} <= SPEED_MAX)))
        else $error("wheel speed above full scale");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[3:2] == swik_pkg::REG_HALF_LENGTH) ##1
        (paddr[3:2] == swik_pkg::REG_HALF_LENGTH) |->
        prdata == {16'h0, $past(pwdata[15:0])})
        else $error("half_length readback mismatch");
endmodule

bind swerve_inverse_kinematics_unit swik_checker #(.SPEED_BITS(SPEED_BITS)) u_swik_checker (.*);

[test/swik_checker.sv]
// Checker for the swerve kinematics unit: predicts wheel speeds and angles and compares results.
module swik_tb_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] hl_q = swik_pkg::HALF_LENGTH_RST;
    logic [15:0] hw_q = swik_pkg::HALF_WIDTH_RST;
    logic [15:0] rs_q = swik_pkg::ROT_SCALE_RST;
    logic [127:0] wheel_q[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shr(longint v, int s);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint sat29(longint v);
        if (v > swik_pkg::ABCD_MAX) return swik_pkg::ABCD_MAX;
        if (v < -swik_pkg::ABCD_MAX) return -swik_pkg::ABCD_MAX;
        return v;
    endfunction

    function automatic logic [15:0] wheel_angle(longint x, longint y);
        logic [31:0] z;
        longint dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < swik_pkg::CORDIC_N; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += swik_pkg::atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= swik_pkg::atan_step(i);
            end
        end
        z += 32'd1 << 15;
        return z[31:16];
    endfunction

    function automatic longint wheel_mag(longint a, longint b);
        logic [63:0] n, r, bt;
        n = 64'(a * a) + 64'(b * b);
        r = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0)
        begin
            if (n >= r + bt)
            begin
                n -= r + bt; r = (r >> 1) + bt;
            end
            else r >>= 1;
            bt >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [127:0] predict_wheels(logic [63:0] cmd);
        longint xs, ys, rv, c, s, x, y, z, dx, dy, tx, ty, yl, yw, a, b, cc, d, m, v;
        longint sp[4];
        logic [31:0] t;
        logic flip;
        logic [127:0] res;
        xs = longint'($signed(cmd[15:0]));
        ys = longint'($signed(cmd[31:16]));
        rv = longint'($signed(cmd[47:32]));
        t = {cmd[63:48], 16'd0};
        flip = 0;
        if ((t - 32'h4000_0000) < 32'h8000_0000)
        begin
            t += 32'h8000_0000;
            flip = 1;
        end
        x = swik_pkg::CORDIC_K;
        y = 0;
        z = longint'($signed(t));
        for (int i = 0; i < swik_pkg::CORDIC_N; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(swik_pkg::atan_step(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(swik_pkg::atan_step(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        tx = rnd_shr(ys * c + xs * s, 25);
        ty = rnd_shr(xs * c - ys * s, 25);
        rv = rv * longint'(rs_q);
        yl = rnd_shr(rv * longint'(hl_q), 19);
        yw = rnd_shr(rv * longint'(hw_q), 19);
        a = sat29(tx - yl);
        b = sat29(tx + yl);
        cc = sat29(ty - yw);
        d = sat29(ty + yw);
        sp[0] = wheel_mag(a, d);
        sp[1] = wheel_mag(b, cc);
        sp[2] = wheel_mag(b, d);
        sp[3] = wheel_mag(a, cc);
        m = sp[0];
        for (int k = 1; k < 4; k++) if (sp[k] > m) m = sp[k];
        for (int k = 0; k < 4; k++)
        begin
            if (m > (64'sd1 <<< 20)) v = ((sp[k] <<< 15) + (m >>> 1)) / m;
            else v = ((sp[k] <<< 15) + (64'sd1 <<< 19)) >>> 20;
            res[16*k +: 16] = v[15:0];
        end
        res[79:64] = wheel_angle(a, cc);
        res[95:80] = wheel_angle(b, cc);
        res[111:96] = wheel_angle(a, d);
        res[127:112] = wheel_angle(b, d);
        return res;
    endfunction

    initial fail_count = 0;
    assign pending = wheel_q.size();

    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    swik_pkg::REG_HALF_LENGTH: hl_q <= pwdata[15:0];
                    swik_pkg::REG_HALF_WIDTH:  hw_q <= pwdata[15:0];
                    swik_pkg::REG_ROT_SCALE:   rs_q <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) wheel_q.push_back(predict_wheels(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (wheel_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", m_tdata);
                end
                else
                begin
                    want = wheel_q.pop_front();
                    for (int f = 0; f < 8; f++)
                    begin
                        if (m_tdata[16*f +: 16] !== want[16*f +: 16])
                        begin
                            fail_count++;
                            if (fail_count <= 10)
                                $display("field %0d: expected %h, got %h", f,
                                         want[16*f +: 16], m_tdata[16*f +: 16]);
                        end
                    end
                end
            end
        end
    end
endmodule

[test/testbench.sv]
// Top of the swerve kinematics testbench: clock, reset, stimulus, register writes and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // x_speed, y_speed, rot_speed, heading
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // speed_fl, fr, bl, br, angle_fl, fr, bl, br
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    int           quiet_cycles;
    bit           hold_sink;
    bit           flooding;

    localparam int WATCHDOG = 20000;

    swerve_inverse_kinematics_unit dut (.*);
    swik_tb_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom_range(0, 65535)), val};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // valid stays up after a transaction until the next command or a drain drops it
    task automatic send_cmd(logic [15:0] x, logic [15:0] y, logic [15:0] r, logic [15:0] h);
        int gap;
        gap = flooding ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {h, r, y, x};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // random field with frequent extremes
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // sink: random stalls, or one long hold while held off
    initial
    begin
        int idle_cycles;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 0;
                repeat (400) @(posedge clk);
                hold_sink = 0;
            end
            else
            begin
                idle_cycles = $urandom_range(0, 3);
                if (idle_cycles != 0)
                begin
                    m_tready <= 0;
                    repeat (idle_cycles) @(posedge clk);
                end
                m_tready <= 1;
                @(posedge clk);
                while (!m_tvalid && !hold_sink) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] dir_x[6];
        logic [15:0] hset[4][3];
        dir_x = '{16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h4000, 16'hffff};
        hset = '{'{16'd0, 16'd0, 16'd0},
                 '{16'hffff, 16'hffff, 16'hffff},
                 '{16'd2816, 16'd2816, 16'd3277},
                 '{16'd256, 16'd512, 16'd32768}};
        rst_n = 0;
        s_tvalid = 0; s_tdata = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        hold_sink = 0; flooding = 0; quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: zero command, extremes of every field, heading quadrants
        send_cmd(0, 0, 0, 0);
        foreach (dir_x[i]) send_cmd(dir_x[i], dir_x[5 - i], 0, 16'(i * 16'h2000));
        send_cmd(16'h8000, 16'h8000, 16'h8000, 16'hffff);
        send_cmd(16'h7fff, 16'h7fff, 16'h7fff, 16'h4000);
        send_cmd(0, 0, 16'h7fff, 16'h8000);
        send_cmd(0, 0, 16'h8000, 16'hc000);
        send_cmd(16'h7fff, 0, 16'h8000, 16'h0001);
        send_cmd(0, 16'h8000, 16'h7fff, 16'h3fff);
        drain();
        for (int ph = 0; ph < 5; ph++)
        begin
            int sel;
            sel = ph % 4;
            reg_write(swik_pkg::REG_HALF_LENGTH, ph == 4 ? 16'($urandom()) : hset[sel][0]);
            reg_write(swik_pkg::REG_HALF_WIDTH, ph == 4 ? 16'($urandom()) : hset[sel][1]);
            reg_write(swik_pkg::REG_ROT_SCALE, ph == 4 ? 16'($urandom()) : hset[sel][2]);
            send_cmd(0, 0, 16'h7fff, 0);
            send_cmd(0, 0, 16'h8000, 0);
            if (ph == 1)
            begin
                // back up the pipe against a stalled sink
                hold_sink = 1;
                flooding = 1;
                repeat (150) send_cmd(pick16(), pick16(), pick16(), 16'($urandom()));
                flooding = 0;
            end
            for (int n = 0; n < 180; n++)
            begin
                if (n == 90) drain();
                send_cmd(pick16(), pick16(), pick16(), 16'($urandom()));
            end
            drain();
        end
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

[swerve_inverse_kinematics_unit.f]
rtl/swik_pkg.sv
rtl/swik_rot_cell.sv
rtl/swik_vec_cell.sv
rtl/swik_sqrt_cell.sv
rtl/swik_div_cell.sv
rtl/swerve_inverse_kinematics_unit.sv
rtl/swik_checker.sv
test/swik_checker.sv
test/testbench.sv
